>>> hw/rtl/abfifo_pkg.sv
// ============================================================================
// abfifo_pkg: shared types and constants of the ASCII byte FIFO
// Beat layouts of both channels, command codes and character constants.
// ============================================================================
package abfifo_pkg;

  localparam int unsigned DefaultDepth = 16;

  // Command codes carried in the input beat.
  localparam logic [1:0] CmdPushChar   = 2'd0;
  localparam logic [1:0] CmdPushNumber = 2'd1;
  localparam logic [1:0] CmdPop        = 2'd2;

  localparam logic [7:0] SpaceChar = 8'h20;
  localparam logic [7:0] DigitZero = 8'h30;

  // A 16-bit value has at most five decimal digits.
  localparam int unsigned MaxDigits = 5;
  localparam int unsigned DigitCntW = $clog2(MaxDigits + 1);

  // Reciprocal of ten, exact for every 16-bit dividend after a shift by 19.
  localparam logic [31:0] Div10Mult  = 32'd52429;
  localparam int unsigned Div10Shift = 19;

  typedef struct packed {
    logic [1:0]  command;
    logic [7:0]  char_byte;
    logic [15:0] number;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       read_valid;
    logic [2:0] accepted;
    logic       is_empty;
    logic       is_full;
  } out_beat_t;

endpackage

>>> hw/rtl/abfifo_ram.sv
// ============================================================================
// abfifo_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; contents undefined at reset.
// ============================================================================
module abfifo_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = abfifo_pkg::DefaultDepth
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> hw/rtl/abfifo_div10.sv
// ============================================================================
// abfifo_div10: divide a 16-bit value by ten
// Quotient by reciprocal multiplication, remainder by shift-and-add back.
// ============================================================================
module abfifo_div10 (
  input  logic [15:0] value,
  output logic [15:0] quot,
  output logic [3:0]  rem
);

  logic [31:0] prod;
  logic [15:0] times10;

  assign prod    = 32'(value) * abfifo_pkg::Div10Mult;
  assign quot    = 16'(prod >> abfifo_pkg::Div10Shift);
  // quot * 10 as quot * 8 + quot * 2.
  assign times10 = 16'({quot, 3'b000}) + 16'({quot, 1'b0});
  assign rem     = 4'(value - times10);

endmodule

>>> hw/rtl/ascii_byte_fifo_with_decimal_push_core.sv
// ============================================================================
// ascii_byte_fifo_with_decimal_push_core: byte FIFO with decimal push
// Circular byte FIFO with a sequenced binary-to-decimal push built around
// one shared divide-by-ten unit.
// ============================================================================
// Each input beat carries one command. A byte push writes one byte; a number
// push turns a 16-bit value into ASCII decimal digits and writes them most
// significant digit first (zero gives the single digit "0"); a pop returns
// the oldest byte, or a space with read_valid low when the FIFO is empty.
// A push into a full FIFO stops there and drops what is left; accepted tells
// how many bytes went in. Every command gives exactly one result beat, with
// the empty and full status after the command. The block works on one
// command at a time and holds in_stall high meanwhile. A number push passes
// its value through the divide-by-ten unit, producing one digit at a time,
// then writes the digits through the single write port of the byte store,
// then closes the push and hands the result to the output register. A byte
// push writes its byte, closes and hands over its result the same way. A pop
// waits for the store's registered read, which is skipped when the FIFO is
// empty. A push that meets a full FIFO ends early and writes no more bytes.
// The result sits in an output register, so a new command is taken while
// the previous result still waits to be collected; the block only waits on
// out_stall when a second result is due.
module ascii_byte_fifo_with_decimal_push_core #(
  parameter int unsigned DEPTH = abfifo_pkg::DefaultDepth
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  abfifo_pkg::in_beat_t  in_beat,
  output logic                  out_valid,
  input  logic                  out_stall,
  output abfifo_pkg::out_beat_t out_beat
);

  localparam int unsigned IdxW    = $clog2(DEPTH);
  localparam int unsigned DigCntW = abfifo_pkg::DigitCntW;

  // Sequencer states.
  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StConv = 3'd1;  // one digit per cycle, least significant first
  localparam logic [2:0] StWrite = 3'd2; // one byte per cycle, most significant first
  localparam logic [2:0] StPopRd = 3'd3; // wait for the registered store read
  localparam logic [2:0] StResp = 3'd4;  // hand the result to the output register

  logic [2:0] state_r, state_nxt;

  // FIFO pointers and full flag.
  logic [IdxW-1:0] wr_idx_r, wr_idx_nxt;
  logic [IdxW-1:0] rd_idx_r, rd_idx_nxt;
  logic            full_r, full_nxt;
  logic            fifo_empty;

  // Command held while it is worked on.
  logic [1:0]         cmd_r, cmd_nxt;
  logic [7:0]         char_r, char_nxt;
  logic [15:0]        num_r, num_nxt;
  logic [3:0]         digit_r [abfifo_pkg::MaxDigits];
  logic [DigCntW-1:0] ndig_r, ndig_nxt;

  // Result being built.
  logic [7:0] rdata_r, rdata_nxt;
  logic       rvalid_r, rvalid_nxt;
  logic [2:0] acc_r, acc_nxt;

  // Output register.
  logic                  out_valid_r, out_valid_nxt;
  abfifo_pkg::out_beat_t out_beat_r, out_beat_nxt;

  // Shared divide-by-ten unit and store ports.
  logic [15:0] div_quot;
  logic [3:0]  div_rem;
  logic        ram_we;
  logic [7:0]  ram_wdata;
  logic [7:0]  ram_rdata;
  logic [IdxW-1:0] wr_idx_inc;
  logic [IdxW-1:0] rd_idx_inc;
  logic [3:0]  cur_digit;
  logic        digit_we;

  abfifo_div10 u_div10 (
    .value (num_r),
    .quot  (div_quot),
    .rem   (div_rem)
  );

  abfifo_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_idx_r),
    .wdata (ram_wdata),
    .raddr (rd_idx_r),
    .rdata (ram_rdata)
  );

  // Pointers wrap after the last slot, so any depth in range works.
  assign wr_idx_inc = (wr_idx_r == IdxW'(DEPTH - 1)) ? '0 : wr_idx_r + IdxW'(1);
  assign rd_idx_inc = (rd_idx_r == IdxW'(DEPTH - 1)) ? '0 : rd_idx_r + IdxW'(1);
  assign fifo_empty = (wr_idx_r == rd_idx_r) && !full_r;

  // The next byte of a push: the held character, or the pending digit.
  assign cur_digit = digit_r[ndig_r - DigCntW'(1)];
  assign ram_wdata = (cmd_r == abfifo_pkg::CmdPushChar) ? char_r
                   : abfifo_pkg::DigitZero + {4'b0000, cur_digit};

  assign in_stall  = (state_r != StIdle);
  assign out_valid = out_valid_r;
  assign out_beat  = out_beat_r;

  always_comb begin
    state_nxt     = state_r;
    wr_idx_nxt    = wr_idx_r;
    rd_idx_nxt    = rd_idx_r;
    full_nxt      = full_r;
    cmd_nxt       = cmd_r;
    char_nxt      = char_r;
    num_nxt       = num_r;
    ndig_nxt      = ndig_r;
    rdata_nxt     = rdata_r;
    rvalid_nxt    = rvalid_r;
    acc_nxt       = acc_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_beat_nxt  = out_beat_r;
    ram_we        = 1'b0;
    digit_we      = 1'b0;

    unique case (state_r)
      StIdle: begin
        if (in_valid) begin
          cmd_nxt    = in_beat.command;
          char_nxt   = in_beat.char_byte;
          num_nxt    = in_beat.number;
          rdata_nxt  = abfifo_pkg::SpaceChar;
          rvalid_nxt = 1'b0;
          acc_nxt    = '0;
          ndig_nxt   = '0;
          case (in_beat.command)
            abfifo_pkg::CmdPushChar: begin
              ndig_nxt  = DigCntW'(1);
              state_nxt = StWrite;
            end
            abfifo_pkg::CmdPushNumber: begin
              state_nxt = StConv;
            end
            abfifo_pkg::CmdPop: begin
              // The store is already reading the slot at the read pointer.
              state_nxt = fifo_empty ? StResp : StPopRd;
            end
            default: begin
              state_nxt = StResp;
            end
          endcase
        end
      end
      StConv: begin
        digit_we = 1'b1;
        num_nxt  = div_quot;
        ndig_nxt = ndig_r + DigCntW'(1);
        if ((div_quot == '0) ||
            (ndig_r == DigCntW'(abfifo_pkg::MaxDigits - 1))) begin
          state_nxt = StWrite;
        end
      end
      StWrite: begin
        if (full_r || (ndig_r == '0)) begin
          state_nxt = StResp;
        end else begin
          ram_we     = 1'b1;
          wr_idx_nxt = wr_idx_inc;
          full_nxt   = (wr_idx_inc == rd_idx_r);
          acc_nxt    = acc_r + 3'd1;
          ndig_nxt   = ndig_r - DigCntW'(1);
        end
      end
      StPopRd: begin
        rdata_nxt  = ram_rdata;
        rvalid_nxt = 1'b1;
        rd_idx_nxt = rd_idx_inc;
        full_nxt   = 1'b0;
        state_nxt  = StResp;
      end
      StResp: begin
        // Status is taken from the pointers as they stand after the command.
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt           = 1'b1;
          out_beat_nxt.read_data  = rdata_r;
          out_beat_nxt.read_valid = rvalid_r;
          out_beat_nxt.accepted   = acc_r;
          out_beat_nxt.is_empty   = fifo_empty;
          out_beat_nxt.is_full    = full_r;
          state_nxt               = StIdle;
        end
      end
      default: begin
        state_nxt = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= StIdle;
      wr_idx_r    <= '0;
      rd_idx_r    <= '0;
      full_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wr_idx_r    <= wr_idx_nxt;
      rd_idx_r    <= rd_idx_nxt;
      full_r      <= full_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    char_r     <= char_nxt;
    num_r      <= num_nxt;
    ndig_r     <= ndig_nxt;
    rdata_r    <= rdata_nxt;
    rvalid_r   <= rvalid_nxt;
    acc_r      <= acc_nxt;
    out_beat_r <= out_beat_nxt;
    if (digit_we) begin
      digit_r[ndig_r] <= div_rem;
    end
  end

endmodule

>>> test/abfifo_result_checker.sv
`timescale 1ns / 100ps
// ============================================================================
// abfifo_result_checker: result predictor and comparator for the byte FIFO
// Watches both channels of the core, predicts each result beat from the
// accepted command beats and compares it field by field, in order.
// ============================================================================
module abfifo_result_checker #(
  parameter int unsigned DEPTH = abfifo_pkg::DefaultDepth
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  abfifo_pkg::in_beat_t  in_beat,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  abfifo_pkg::out_beat_t out_beat,
  output int                    fail_count,
  output int                    outstanding,
  output int                    beats_checked,
  output int                    full_results,
  output int                    empty_pops,
  output int                    short_pushes
);

  localparam int unsigned Radix = 10;

  // Shadow copy of the FIFO.
  logic [7:0]  ring_mem [DEPTH];
  int unsigned wr_slot   = 0;
  int unsigned rd_slot   = 0;
  bit          ring_full = 1'b0;

  abfifo_pkg::out_beat_t expected_results [$];

  function automatic bit ring_empty();
    return (wr_slot == rd_slot) && !ring_full;
  endfunction

  function automatic bit store_byte(input logic [7:0] data);
    if (ring_full) return 1'b0;
    ring_mem[wr_slot] = data;
    wr_slot = (wr_slot == DEPTH - 1) ? 0 : wr_slot + 1;
    if (wr_slot == rd_slot) ring_full = 1'b1;
    return 1'b1;
  endfunction

  function automatic abfifo_pkg::out_beat_t apply_command(input abfifo_pkg::in_beat_t beat);
    abfifo_pkg::out_beat_t res;
    logic [7:0]            digit_buf [abfifo_pkg::MaxDigits];
    int unsigned           value;
    int unsigned           ndig;
    res = '0;
    res.read_data = abfifo_pkg::SpaceChar;
    case (beat.command)
      abfifo_pkg::CmdPushChar: begin
        res.accepted = {2'b00, store_byte(beat.char_byte)};
        if (res.accepted == 0) short_pushes++;
      end
      abfifo_pkg::CmdPushNumber: begin
        value = beat.number;
        ndig  = 0;
        // Digits are gathered least significant first and written in reverse.
        do begin
          digit_buf[ndig] = abfifo_pkg::DigitZero + 8'(value % Radix);
          value = value / Radix;
          ndig++;
        end while (value != 0);
        while (ndig != 0) begin
          if (!store_byte(digit_buf[ndig - 1])) break;
          res.accepted = res.accepted + 3'd1;
          ndig--;
        end
        if (ndig != 0) short_pushes++;
      end
      abfifo_pkg::CmdPop: begin
        if (ring_empty()) begin
          empty_pops++;
        end else begin
          res.read_data  = ring_mem[rd_slot];
          res.read_valid = 1'b1;
          rd_slot   = (rd_slot == DEPTH - 1) ? 0 : rd_slot + 1;
          ring_full = 1'b0;
        end
      end
      default: ;
    endcase
    res.is_empty = ring_empty();
    res.is_full  = ring_full;
    return res;
  endfunction

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("%0t ns: result beat %0d, %s expected 0x%0h, actual 0x%0h",
               $time, beats_checked, name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    abfifo_pkg::out_beat_t want;
    if (!rst_n) begin
      expected_results.delete();
      wr_slot     = 0;
      rd_slot     = 0;
      ring_full   = 1'b0;
      outstanding <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $display("%0t ns: unexpected result beat, expected none, actual 0x%0h",
                   $time, out_beat);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          check_field("read_data", want.read_data, out_beat.read_data);
          check_field("read_valid", want.read_valid, out_beat.read_valid);
          check_field("accepted", want.accepted, out_beat.accepted);
          check_field("is_empty", want.is_empty, out_beat.is_empty);
          check_field("is_full", want.is_full, out_beat.is_full);
          if (want.is_full) full_results++;
          beats_checked++;
        end
      end
      if (in_valid && !in_stall) expected_results.push_back(apply_command(in_beat));
      outstanding <= expected_results.size();
    end
  end

endmodule

>>> test/ascii_byte_fifo_with_decimal_push_core_tb.sv
`timescale 1ns / 100ps
// ============================================================================
// ascii_byte_fifo_with_decimal_push_core_tb: testbench of the byte FIFO core
// Drives command beats into the core, collects its result beats under
// varying back-pressure and leaves prediction and comparison to the checker.
// ============================================================================
module ascii_byte_fifo_with_decimal_push_core_tb;

  // The fourth command code has no function; the core must answer it as a
  // no-operation with an idle result.
  localparam logic [1:0] CmdUnused = 2'd3;

  localparam int RandomItems    = 1830;
  localparam int LongHoldCycles = 300;
  localparam int SettleCycles   = 40;
  localparam int CycleLimit     = 400000;
  localparam int RegimeLength   = 64;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  abfifo_pkg::in_beat_t  in_beat   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  abfifo_pkg::out_beat_t out_beat;

  // Idling odds in percent. The sender's figure is only read by the process
  // that drives beats; the receiver's is handed over with nonblocking writes.
  int send_gap_pct   = 0;
  int recv_stall_pct = 0;

  // The long output hold: requested once by the stimulus, timed by the
  // receiver process on its own.
  bit want_long_hold = 1'b0;
  bit long_hold_done = 1'b0;
  int hold_count     = 0;

  int cycle_count = 0;
  int beats_sent  = 0;

  int fail_count;
  int outstanding;
  int beats_checked;
  int full_results;
  int empty_pops;
  int short_pushes;

  always #6 clk = ~clk;

  ascii_byte_fifo_with_decimal_push_core #(
    .DEPTH(abfifo_pkg::DefaultDepth)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_beat  (in_beat),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_beat (out_beat)
  );

  abfifo_result_checker #(
    .DEPTH(abfifo_pkg::DefaultDepth)
  ) result_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_beat      (in_beat),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_beat     (out_beat),
    .fail_count   (fail_count),
    .outstanding  (outstanding),
    .beats_checked(beats_checked),
    .full_results (full_results),
    .empty_pops   (empty_pops),
    .short_pushes (short_pushes)
  );

  // Receiver. Outside the long hold it stalls at random with the current
  // odds; during the hold it keeps out_stall high for a fixed count of
  // cycles, which lets the core fill its output register and then hold off
  // the sender through in_stall.
  always @(posedge clk) begin
    if (want_long_hold && !long_hold_done) begin
      if (hold_count == LongHoldCycles) begin
        long_hold_done <= 1'b1;
        out_stall      <= 1'b0;
      end else begin
        hold_count <= hold_count + 1;
        out_stall  <= 1'b1;
      end
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Watchdog. The limit is many times the slowest legal run, which is the
  // longest number push for every beat plus the worst idling on both sides.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("Timed out after %0d cycles with %0d results outstanding.",
               CycleLimit, outstanding);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic abfifo_pkg::in_beat_t make_beat(input logic [1:0]  cmd,
                                                     input logic [7:0]  ch,
                                                     input logic [15:0] num);
    abfifo_pkg::in_beat_t beat;
    beat.command   = cmd;
    beat.char_byte = ch;
    beat.number    = num;
    return beat;
  endfunction

  // Numbers are spread evenly over their digit counts, so that short pushes
  // are as common as five-digit ones, with some fully random values on top.
  function automatic logic [15:0] random_number();
    case ($urandom_range(5))
      0:       return 16'($urandom_range(9));
      1:       return 16'($urandom_range(99, 10));
      2:       return 16'($urandom_range(999, 100));
      3:       return 16'($urandom_range(9999, 1000));
      4:       return 16'($urandom_range(65535, 10000));
      default: return 16'($urandom);
    endcase
  endfunction

  // Offers one beat and returns at the clock edge at which it is accepted.
  // Any idle cycles come first, with valid low; once raised, valid and the
  // payload hold steady until the core takes the beat.
  task automatic offer_beat(input abfifo_pkg::in_beat_t beat);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_beat  <= beat;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    beats_sent++;
  endtask

  initial begin
    int unsigned draw;
    int unsigned push_pct;
    int          regime_left;
    int          random_items;
    logic [1:0]  cmd;
    push_pct     = 35;
    regime_left  = 0;
    random_items = 0;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // First regime: the sender idles now and then, the receiver mostly.
    send_gap_pct = 19;
    recv_stall_pct <= 66;
    @(posedge clk);

    // Directed part. A pop and a void command on the empty FIFO, then the
    // extreme bytes, zero as a single digit and the largest number. The
    // number pushes then fill the sixteen slots, the last one losing its
    // final digit, and a byte push into the full FIFO is refused outright.
    // Sixteen pops drain everything and one more finds the FIFO empty again.
    offer_beat(make_beat(abfifo_pkg::CmdPop, 8'hFF, 16'hFFFF));
    offer_beat(make_beat(CmdUnused, 8'h00, 16'h0000));
    offer_beat(make_beat(abfifo_pkg::CmdPushChar, 8'h00, 16'hFFFF));
    offer_beat(make_beat(abfifo_pkg::CmdPushChar, 8'hFF, 16'h0000));
    offer_beat(make_beat(abfifo_pkg::CmdPushNumber, 8'hFF, 16'd0));
    offer_beat(make_beat(abfifo_pkg::CmdPushNumber, 8'h00, 16'd65535));
    offer_beat(make_beat(abfifo_pkg::CmdPushNumber, 8'h5A, 16'd12345));
    offer_beat(make_beat(abfifo_pkg::CmdPushNumber, 8'hA5, 16'd4321));
    offer_beat(make_beat(abfifo_pkg::CmdPushChar, 8'hA5, 16'd7));
    offer_beat(make_beat(CmdUnused, 8'hFF, 16'hFFFF));
    repeat (abfifo_pkg::DefaultDepth + 1) begin
      offer_beat(make_beat(abfifo_pkg::CmdPop, 8'h00, 16'h0000));
    end

    // Random part. Every stretch of beats gets a fresh push rate: a low one
    // drains the FIFO towards empty, a middling one hovers, and a high one
    // drives it full so that refused and cut-short pushes are common. The
    // unused fields of each beat carry random values as well.
    while (random_items < RandomItems) begin
      if (random_items == RandomItems / 3 && send_gap_pct == 19) begin
        // Second regime: the sender idles a lot, the receiver a little.
        send_gap_pct = 66;
        recv_stall_pct <= 19;
      end else if (random_items == 2 * RandomItems / 3 && !want_long_hold) begin
        // Third regime: no idling, opened by the long output hold.
        send_gap_pct = 0;
        recv_stall_pct <= 0;
        want_long_hold <= 1'b1;
      end

      if (regime_left == 0) begin
        case ($urandom_range(2))
          0:       push_pct = 20;
          1:       push_pct = 35;
          default: push_pct = 60;
        endcase
        regime_left = RegimeLength;
      end
      regime_left--;

      draw = $urandom_range(99);
      if (draw < 3) begin
        cmd = CmdUnused;
      end else if (draw < 3 + push_pct) begin
        cmd = $urandom_range(1) ? abfifo_pkg::CmdPushNumber : abfifo_pkg::CmdPushChar;
      end else begin
        cmd = abfifo_pkg::CmdPop;
      end
      offer_beat(make_beat(cmd, 8'($urandom), random_number()));
      if (cmd != CmdUnused) random_items++;
    end
    in_valid <= 1'b0;

    // Let every expected result arrive, then leave room for a stray one.
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);

    $display("Run covered %0d command beats and %0d checked results under three",
             beats_sent, beats_checked);
    $display("idling regimes and a long hold: %0d full, %0d empty pops, %0d short pushes.",
             full_results, empty_pops, short_pushes);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
